FILE: design/baud_divisor_selector_top_macros.svh
// ----------------------------------------------------------------------------
// baud divisor selector assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef BAUD_DIVISOR_SELECTOR_TOP_MACROS_SVH
`define BAUD_DIVISOR_SELECTOR_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define BDS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define BDS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/bds_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bds_pkg
// shared widths, constants and microcode for the baud divisor selector
// ----------------------------------------------------------------------------
package bds_pkg;

    localparam int DATA_W       = 32;
    localparam int EXP_W        = 4;
    localparam int TMC_W        = 8;
    localparam int QSAT_W       = 9;
    localparam int OUT_W        = 48;
    localparam int APB_AW       = 3;
    localparam int APB_DW       = 32;
    localparam int STEP_W       = 3;

    localparam logic [DATA_W-1:0] BASE_CLK_RESET = 32'd9830400;
    localparam logic [EXP_W-1:0]  START_EXP      = 4'd9;
    localparam logic [QSAT_W-1:0] SEARCH_LIMIT   = 9'd128;
    localparam logic [QSAT_W-1:0] TMC_MAX        = 9'd255;
    localparam logic [QSAT_W-1:0] TMC_FULL       = 9'd256;

    // register index of base_clock_hz
    localparam logic REG_BASE_CLK = 1'b0;

    // wait conditions
    localparam logic [1:0] W_NONE = 2'd0;
    localparam logic [1:0] W_IN   = 2'd1;
    localparam logic [1:0] W_DIV  = 2'd2;
    localparam logic [1:0] W_OUT  = 2'd3;

    // jump conditions
    localparam logic [1:0] J_NEXT   = 2'd0;
    localparam logic [1:0] J_ALWAYS = 2'd1;
    localparam logic [1:0] J_LOOP   = 2'd2;
    localparam logic [1:0] J_ZERO   = 2'd3;

    // program steps
    localparam logic [STEP_W-1:0] S_ACCEPT   = 3'd0;
    localparam logic [STEP_W-1:0] S_DIV_GO   = 3'd1;
    localparam logic [STEP_W-1:0] S_DIV_WAIT = 3'd2;
    localparam logic [STEP_W-1:0] S_TEST     = 3'd3;
    localparam logic [STEP_W-1:0] S_FIX      = 3'd4;
    localparam logic [STEP_W-1:0] S_FIN_GO   = 3'd5;
    localparam logic [STEP_W-1:0] S_FIN_WAIT = 3'd6;
    localparam logic [STEP_W-1:0] S_OUT      = 3'd7;

    typedef struct packed {
        logic [1:0]        wait_sel;
        logic [1:0]        jmp_sel;
        logic [STEP_W-1:0] target;
        logic              ld_in;
        logic              div_go;
        logic              use_tmc;
        logic              dec_br;
        logic              fix;
        logic              emit;
    } ctrl_t;

    function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
        ctrl_t c;
        c = '0;
        unique case (step)
            S_ACCEPT:
            begin
                c.wait_sel = W_IN;
                c.jmp_sel  = J_ZERO;
                c.target   = S_FIN_GO;
                c.ld_in    = 1'b1;
            end
            S_DIV_GO:
            begin
                c.div_go   = 1'b1;
            end
            S_DIV_WAIT:
            begin
                c.wait_sel = W_DIV;
            end
            S_TEST:
            begin
                c.jmp_sel  = J_LOOP;
                c.target   = S_DIV_GO;
                c.dec_br   = 1'b1;
            end
            S_FIX:
            begin
                c.fix      = 1'b1;
            end
            S_FIN_GO:
            begin
                c.div_go   = 1'b1;
                c.use_tmc  = 1'b1;
            end
            S_FIN_WAIT:
            begin
                c.wait_sel = W_DIV;
            end
            S_OUT:
            begin
                c.wait_sel = W_OUT;
                c.jmp_sel  = J_ALWAYS;
                c.target   = S_ACCEPT;
                c.emit     = 1'b1;
            end
            default:
            begin
                c = '0;
            end
        endcase
        return c;
    endfunction

endpackage

FILE: design/bds_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bds_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module bds_div
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [bds_pkg::DATA_W-1:0] dividend,
    input  logic [bds_pkg::DATA_W-1:0] divisor,
    output logic                       done,
    output logic [bds_pkg::DATA_W-1:0] quotient
);

    localparam int CNT_W = $clog2(bds_pkg::DATA_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(bds_pkg::DATA_W - 1);

    logic                       busy_reg,  busy_next;
    logic                       done_reg,  done_next;
    logic [CNT_W-1:0]           cnt_reg,   cnt_next;
    logic [bds_pkg::DATA_W-1:0] rem_reg,   rem_next;
    logic [bds_pkg::DATA_W-1:0] quo_reg,   quo_next;
    logic [bds_pkg::DATA_W-1:0] dvs_reg,   dvs_next;

    logic [bds_pkg::DATA_W:0]   trial;
    logic                       fits;

    assign trial = {rem_reg, quo_reg[bds_pkg::DATA_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            done_next = 1'b0;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            // shift in the next dividend bit, subtract where it fits
            rem_next = fits ? bds_pkg::DATA_W'(trial - {1'b0, dvs_reg})
                            : trial[bds_pkg::DATA_W-1:0];
            quo_next = {quo_reg[bds_pkg::DATA_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: design/baud_divisor_selector_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// baud_divisor_selector_top
// picks prescale exponent and time constant for a requested bit rate
// ----------------------------------------------------------------------------
// One requested rate in, one setting out. The block searches the prescale
// exponent from 9 downwards, dividing base_clock_hz by 2^br times the rate,
// and stops once the quotient exceeds 128 or br reaches 1; it then fixes up
// the time constant (a zero quotient gives br 0 and tmc 1, a quotient above
// 255 gives tmc 256, sent as 0) and divides once more for the rate reached.
// All divisions share one serial divider. One item is worked at a time; the
// finished word sits in an output register so the next request can be taken
// while it waits. base_clock_hz is written over the APB port at address 0 and
// should only change while the block is idle.
// ----------------------------------------------------------------------------
module baud_divisor_selector_top
(
    input  logic                       clk,
    input  logic                       rst_n,

    // slave stream: tdata = requested_rate[31:0]
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [bds_pkg::DATA_W-1:0] s_axis_tdata,

    // master stream: tdata = prescale_exponent[3:0], time_constant[11:4],
    // achieved_rate[43:12], zero padding [47:44]
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [bds_pkg::OUT_W-1:0]  m_axis_tdata,

    // apb configuration port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bds_pkg::APB_AW-1:0] paddr,
    input  logic [bds_pkg::APB_DW-1:0] pwdata,
    output logic [bds_pkg::APB_DW-1:0] prdata,
    output logic                       pready
);

    // configuration register
    logic [bds_pkg::DATA_W-1:0] base_reg, base_next;
    logic                       cfg_wr;

    // sequencer and datapath
    logic [bds_pkg::STEP_W-1:0] step_reg, step_next;
    logic [bds_pkg::DATA_W-1:0] rate_reg, rate_next;
    logic [bds_pkg::EXP_W-1:0]  br_reg,   br_next;
    logic [bds_pkg::QSAT_W-1:0] tmc_reg,  tmc_next;

    // output word register
    logic                       ovalid_reg, ovalid_next;
    logic [bds_pkg::OUT_W-1:0]  odata_reg,  odata_next;

    bds_pkg::ctrl_t             ctrl;
    logic                       go;
    logic                       taken;
    logic                       out_free;
    logic                       loop_cond;
    logic [bds_pkg::QSAT_W-1:0] q_sat;

    logic                       div_start;
    logic                       div_done;
    logic [bds_pkg::DATA_W-1:0] div_dividend;
    logic [bds_pkg::DATA_W-1:0] div_divisor;
    logic [bds_pkg::DATA_W-1:0] div_quo;

    // ------------------------------------------------------------------
    // apb: write on the access cycle, index taken from paddr[2]
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[2] == bds_pkg::REG_BASE_CLK);
    assign prdata = (paddr[2] == bds_pkg::REG_BASE_CLK) ? base_reg : '0;

    assign base_next = cfg_wr ? pwdata : base_reg;

    // ------------------------------------------------------------------
    // microcode fetch and step control
    // ------------------------------------------------------------------
    assign ctrl     = bds_pkg::ucode(step_reg);
    assign out_free = !ovalid_reg || m_axis_tready;

    // divider quotient clipped to 9 bits, 256 stands for anything above 255
    assign q_sat     = (div_quo > bds_pkg::DATA_W'(bds_pkg::TMC_MAX))
                       ? bds_pkg::TMC_FULL : div_quo[bds_pkg::QSAT_W-1:0];
    assign loop_cond = (br_reg > bds_pkg::EXP_W'(1)) && (q_sat <= bds_pkg::SEARCH_LIMIT);

    always_comb
    begin
        unique case (ctrl.wait_sel)
            bds_pkg::W_NONE: go = 1'b1;
            bds_pkg::W_IN:   go = s_axis_tvalid;
            bds_pkg::W_DIV:  go = div_done;
            bds_pkg::W_OUT:  go = out_free;
            default:         go = 1'b0;
        endcase
    end

    always_comb
    begin
        unique case (ctrl.jmp_sel)
            bds_pkg::J_NEXT:   taken = 1'b0;
            bds_pkg::J_ALWAYS: taken = 1'b1;
            bds_pkg::J_LOOP:   taken = loop_cond;
            bds_pkg::J_ZERO:   taken = (s_axis_tdata == '0);
            default:           taken = 1'b0;
        endcase
    end

    // input is taken only on the accept step
    assign s_axis_tready = (ctrl.wait_sel == bds_pkg::W_IN);

    always_comb
    begin
        step_next = step_reg;
        if (go)
        begin
            step_next = taken ? ctrl.target : step_reg + 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // datapath
    // ------------------------------------------------------------------
    always_comb
    begin
        rate_next = rate_reg;
        br_next   = br_reg;
        tmc_next  = tmc_reg;
        if (go && ctrl.ld_in)
        begin
            // zero request keeps these and goes straight to the final divide
            rate_next = s_axis_tdata;
            br_next   = bds_pkg::START_EXP;
            tmc_next  = bds_pkg::TMC_FULL;
        end
        if (ctrl.dec_br && taken)
        begin
            br_next = br_reg - 1'b1;
        end
        if (ctrl.fix)
        begin
            if (q_sat == '0)
            begin
                // request faster than the clock: run undivided
                br_next  = '0;
                tmc_next = bds_pkg::QSAT_W'(1);
            end
            else
            begin
                tmc_next = q_sat;
            end
        end
    end

    // base >> br divided by the rate equals base / (2^br * rate)
    assign div_start    = ctrl.div_go;
    assign div_dividend = base_reg >> br_reg;
    assign div_divisor  = ctrl.use_tmc ? bds_pkg::DATA_W'(tmc_reg) : rate_reg;

    bds_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    // ------------------------------------------------------------------
    // output word register
    // ------------------------------------------------------------------
    always_comb
    begin
        ovalid_next = ovalid_reg;
        odata_next  = odata_reg;
        if (m_axis_tready)
        begin
            ovalid_next = 1'b0;
        end
        if (go && ctrl.emit)
        begin
            ovalid_next = 1'b1;
            odata_next  = {{(bds_pkg::OUT_W - bds_pkg::DATA_W - bds_pkg::TMC_W
                             - bds_pkg::EXP_W){1'b0}},
                           div_quo, tmc_reg[bds_pkg::TMC_W-1:0], br_reg};
        end
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = odata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg   <= bds_pkg::BASE_CLK_RESET;
            step_reg   <= bds_pkg::S_ACCEPT;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            base_reg   <= base_next;
            step_reg   <= step_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rate_reg  <= rate_next;
        br_reg    <= br_next;
        tmc_reg   <= tmc_next;
        odata_reg <= odata_next;
    end

endmodule

FILE: design/bds_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bds_chk
// port-level checks for the baud divisor selector
// ----------------------------------------------------------------------------
`include "baud_divisor_selector_top_macros.svh"

module bds_chk
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       s_axis_tvalid,
    input logic                       s_axis_tready,
    input logic                       m_axis_tvalid,
    input logic                       m_axis_tready,
    input logic [bds_pkg::OUT_W-1:0]  m_axis_tdata,
    input logic                       pready
);

    `BDS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output word changed while stalled")

    `BDS_ASSERT_NOW(a_br_range, m_axis_tvalid, m_axis_tdata[3:0] <= 4'd9, "prescale exponent above nine")

    `BDS_ASSERT_NOW(a_br0_tmc1, m_axis_tvalid && (m_axis_tdata[3:0] == 4'd0), m_axis_tdata[11:4] == 8'd1, "undivided setting without time constant one")

    `BDS_ASSERT_NEXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second request taken while one is in work")

    `BDS_ASSERT_NOW(a_pready, 1'b1, pready, "pready dropped")

endmodule

bind baud_divisor_selector_top bds_chk u_bds_chk
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .pready        (pready)
);

FILE: sim/baud_divisor_selector_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// baud_divisor_selector_checker
// watches the request, setting and apb channels of the divisor selector,
// works out each expected setting and compares it with the word sent out
// ----------------------------------------------------------------------------
module baud_divisor_selector_checker
(
    input  logic                       clk,
    input  logic                       rst_n,

    input  logic                       s_axis_tvalid,
    input  logic                       s_axis_tready,
    input  logic [bds_pkg::DATA_W-1:0] s_axis_tdata,

    input  logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    input  logic [bds_pkg::OUT_W-1:0]  m_axis_tdata,

    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bds_pkg::APB_AW-1:0] paddr,
    input  logic [bds_pkg::APB_DW-1:0] pwdata,
    input  logic                       pready,

    output int                         outstanding,
    output int                         mismatches,
    output int                         settings_checked
);

    typedef struct packed {
        logic [31:0] achieved;
        logic [7:0]  tmc;
        logic [3:0]  br;
    } divisor_setting_t;

    typedef struct packed {
        logic [31:0]      rate;
        divisor_setting_t setting;
    } rate_request_t;

    logic [31:0]     base_clock;
    rate_request_t   pending_settings[$];
    rate_request_t   want;
    divisor_setting_t got;

    // exponent search from the top, then tmc clamp and the rate reached
    function automatic divisor_setting_t select_divisor(input logic [31:0] base,
                                                        input logic [31:0] rate);
        divisor_setting_t s;
        logic [63:0]      quot;
        logic [63:0]      span;
        logic [63:0]      reached;
        logic [3:0]       br;
        if (rate == 32'd0)
        begin
            br      = bds_pkg::START_EXP;
            quot    = {55'd0, bds_pkg::TMC_FULL};
        end
        else
        begin
            br   = bds_pkg::START_EXP;
            quot = {32'd0, base} / ((64'd1 << br) * {32'd0, rate});
            while (br > 4'd1 && quot <= {55'd0, bds_pkg::SEARCH_LIMIT})
            begin
                br   = br - 4'd1;
                quot = {32'd0, base} / ((64'd1 << br) * {32'd0, rate});
            end
            if (quot == 64'd0)
            begin
                quot = 64'd1;
                br   = 4'd0;
            end
            else if (quot > {55'd0, bds_pkg::TMC_MAX})
            begin
                quot = {55'd0, bds_pkg::TMC_FULL};
            end
        end
        span       = (64'd1 << br) * quot;
        reached    = {32'd0, base} / span;
        s.br       = br;
        s.tmc      = quot[7:0];
        s.achieved = reached[31:0];
        return s;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_clock = bds_pkg::BASE_CLK_RESET;
            pending_settings.delete();
            outstanding      = 0;
            mismatches       = 0;
            settings_checked = 0;
        end
        else
        begin
            // only register index 0 exists, the rest is ignored
            if (psel && penable && pwrite && pready &&
                paddr[bds_pkg::APB_AW-1:2] == bds_pkg::REG_BASE_CLK)
                base_clock = pwdata;

            if (s_axis_tvalid && s_axis_tready)
            begin
                want.rate    = s_axis_tdata;
                want.setting = select_divisor(base_clock, s_axis_tdata);
                pending_settings.push_back(want);
            end

            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[43:0];
                if (pending_settings.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: setting word with no request waiting: br %0d tmc %0d rate %0d",
                             $realtime, got.br, got.tmc, got.achieved);
                end
                else
                begin
                    want = pending_settings.pop_front();
                    settings_checked++;
                    if (got.br !== want.setting.br || got.tmc !== want.setting.tmc ||
                        got.achieved !== want.setting.achieved)
                    begin
                        mismatches++;
                        $display("%0t: request %0d: expected br %0d tmc %0d rate %0d, got br %0d tmc %0d rate %0d",
                                 $realtime, want.rate, want.setting.br, want.setting.tmc,
                                 want.setting.achieved, got.br, got.tmc, got.achieved);
                    end
                end
            end
            outstanding = pending_settings.size();
        end
    end

endmodule

FILE: sim/baud_divisor_selector_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// baud_divisor_selector_top_tb
// drives requested rates and base clock settings into the divisor selector
// ----------------------------------------------------------------------------
// Runs phases, each under one base clock value, from phase 1 written over apb
// while the block is idle. Each phase offers the zero and full-scale rates,
// the first one a directed list of boundary rates, then random rates spread
// over the whole range. Both stream sides idle at random, one phase runs
// without idling, and the output side holds off once for a long stretch so
// the block backs up. The checker beside the block does all the comparing.
// ----------------------------------------------------------------------------
module baud_divisor_selector_top_tb;

    localparam int PHASES          = 7;
    localparam int RATES_PER_PHASE = 215;
    localparam int IDLE_PERCENT    = 18;
    localparam int HOLD_CYCLES     = 3000;
    localparam int HOLD_AFTER      = 400;
    localparam int CALM_PHASE      = 4;
    localparam int STRAY_PHASE     = 3;
    localparam int DRAIN_CYCLES    = 400;

    // apb byte addresses: base clock at index 0, index 1 is unmapped
    localparam logic [bds_pkg::APB_AW-1:0] ADDR_BASE_CLK = {bds_pkg::REG_BASE_CLK, 2'b00};
    localparam logic [bds_pkg::APB_AW-1:0] ADDR_UNMAPPED = 3'd4;

    // phase 0 keeps the reset value, the last phase draws its own
    localparam logic [31:0] PHASE_CLOCKS [PHASES] = '{
        bds_pkg::BASE_CLK_RESET, 32'd1, 32'hFFFF_FFFF, 32'd0,
        32'd14745600, 32'd3686400, 32'd0
    };

    localparam logic [31:0] STANDARD_RATES [12] = '{
        32'd300, 32'd1200, 32'd2400, 32'd4800, 32'd9600, 32'd19200,
        32'd38400, 32'd57600, 32'd115200, 32'd230400, 32'd460800, 32'd921600
    };

    // boundary rates against the reset clock of 9830400 Hz
    localparam logic [31:0] DIRECTED_RATES [20] = '{
        32'h8000_0000,    // product needs more than 32 bits
        32'd150,          // quotient exactly 128 at the top exponent
        32'd149,
        32'd75,           // quotient 256, held at full count
        32'd76,           // quotient just inside 255
        32'd50,
        32'd9830400,      // rate equals clock, quotient below one
        32'd9830401,
        32'd4915200,      // quotient exactly one at br 1
        32'd4915199,
        32'd4915201,
        32'd2457600,
        32'd38401,        // search runs down to br 1
        32'd9600,
        32'd19200,
        32'd115200,
        32'd57600,
        32'd1200,
        32'd2,
        32'd300
    };

    logic                       clk = 1'b0;
    logic                       rst_n;

    logic                       s_axis_tvalid;
    logic                       s_axis_tready;
    logic [bds_pkg::DATA_W-1:0] s_axis_tdata;     // requested_rate[31:0]

    logic                       m_axis_tvalid;
    logic                       m_axis_tready;
    logic [bds_pkg::OUT_W-1:0]  m_axis_tdata;     // br[3:0], tmc[11:4], rate[43:12]

    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [bds_pkg::APB_AW-1:0] paddr;
    logic [bds_pkg::APB_DW-1:0] pwdata;
    logic [bds_pkg::APB_DW-1:0] prdata;
    logic                       pready;

    int                         outstanding;
    int                         mismatches;
    int                         settings_checked;

    logic [31:0]                base_now;
    logic                       calm;
    int                         rates_sent;
    int                         words_out;
    int                         hold_left;
    int                         longest_hold;

    baud_divisor_selector_top dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    baud_divisor_selector_checker checker_i
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .s_axis_tvalid    (s_axis_tvalid),
        .s_axis_tready    (s_axis_tready),
        .s_axis_tdata     (s_axis_tdata),
        .m_axis_tvalid    (m_axis_tvalid),
        .m_axis_tready    (m_axis_tready),
        .m_axis_tdata     (m_axis_tdata),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .pready           (pready),
        .outstanding      (outstanding),
        .mismatches       (mismatches),
        .settings_checked (settings_checked)
    );

    // 12 ns period
    always #6 clk = ~clk;

    // hard stop well beyond the slowest legal run
    initial
    begin
        #40_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // apb write: setup cycle, then access cycle; pready is tied high
    task automatic write_reg(input logic [bds_pkg::APB_AW-1:0] addr,
                             input logic [bds_pkg::APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // offer one requested rate; tready is read mid-cycle, where it is stable
    task automatic send_rate(input logic [31:0] rate);
        logic taken;
        if (!calm)
        begin
            while ($urandom_range(0, 99) < IDLE_PERCENT)
            begin
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= rate;
        do
        begin
            @(negedge clk);
            taken = s_axis_tready;
            @(posedge clk);
        end
        while (!taken);
        rates_sent++;
    endtask

    // random rate: full range, log spread, typical ranges, and rates
    // near clock / 2^k where quotients land on exact boundaries
    function automatic logic [31:0] pick_rate();
        logic [31:0] r;
        case ($urandom_range(0, 15))
            0, 1, 2:
            begin
                r = $urandom;
            end
            3, 4, 5, 6:
            begin
                r = $urandom >> $urandom_range(0, 31);
            end
            7, 8, 9:
            begin
                r = $urandom_range(1, 500000);
            end
            10, 11:
            begin
                r = STANDARD_RATES[$urandom_range(0, 11)];
            end
            12, 13, 14:
            begin
                r = (base_now >> $urandom_range(0, 24)) + $urandom_range(0, 2) - 1;
            end
            default:
            begin
                r = 32'd0;
            end
        endcase
        return r;
    endfunction

    // output side: random back-pressure, one long hold-off counted here
    initial
    begin
        m_axis_tready = 1'b0;
        words_out     = 0;
        hold_left     = 0;
        longest_hold  = 0;
        forever
        begin
            @(negedge clk);
            if (m_axis_tvalid && m_axis_tready)
                words_out++;
            @(posedge clk);
            if (hold_left > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end
            else if (longest_hold == 0 && words_out >= HOLD_AFTER)
            begin
                // block fills up behind this while the sender keeps offering
                m_axis_tready <= 1'b0;
                hold_left    = HOLD_CYCLES - 1;
                longest_hold = HOLD_CYCLES;
            end
            else
            begin
                m_axis_tready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
            end
        end
    end

    // stimulus and verdict
    initial
    begin
        int          phase;
        logic [31:0] clock_value;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        calm          = 1'b0;
        rates_sent    = 0;
        base_now      = bds_pkg::BASE_CLK_RESET;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (phase = 0; phase < PHASES; phase++)
        begin
            // block is idle here: nothing in flight, nothing waiting
            if (phase != 0)
            begin
                clock_value = (phase == PHASES - 1) ? $urandom : PHASE_CLOCKS[phase];
                if (phase == STRAY_PHASE)
                begin
                    write_reg(ADDR_UNMAPPED, $urandom);
                    // bus goes idle before the next transfer
                    @(posedge clk);
                end
                write_reg(ADDR_BASE_CLK, clock_value);
                base_now = clock_value;
            end
            calm = (phase == CALM_PHASE);

            // zero request, slowest step and full-scale request each phase
            send_rate(32'd0);
            send_rate(32'd1);
            send_rate(32'hFFFF_FFFF);
            if (phase == 0)
                foreach (DIRECTED_RATES[i])
                    send_rate(DIRECTED_RATES[i]);

            repeat (RATES_PER_PHASE)
                send_rate(pick_rate());

            s_axis_tvalid <= 1'b0;
            @(posedge clk);
            while (outstanding != 0)
                @(posedge clk);
        end

        // settle in case a stray word follows
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d rate requests under %0d base clock settings, %0d settings checked",
                 rates_sent, PHASES, settings_checked);
        $display("one phase free of idling, output held off once for %0d cycles",
                 longest_hold);
        if (mismatches == 0 && outstanding == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+design
design/bds_pkg.sv
design/bds_div.sv
design/baud_divisor_selector_top.sv
design/bds_chk.sv
sim/baud_divisor_selector_checker.sv
sim/baud_divisor_selector_top_tb.sv
